/* hw/rtl/aes_sbox_forward_inverse_macros.svh */
// Assertion helpers used by the checker file.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef AES_SBOX_FORWARD_INVERSE_MACROS_SVH
`define AES_SBOX_FORWARD_INVERSE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define AESSB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define AESSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/aessb_pkg.sv */
`default_nettype none

package aessb_pkg;

  // Pipeline depth: input/affine stage, three multiply stages, output stage
  localparam int NUM_STAGES = 5;

  localparam logic [7:0] GF_POLY      = 8'h1B;
  localparam logic [7:0] AFFINE_FWD_C = 8'h63;
  localparam logic [7:0] AFFINE_INV_C = 8'h05;

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_INV = 1'b1
  } aessb_op_t;

  // Per-stage occupancy and load enables
  typedef struct packed {
    logic [NUM_STAGES-1:0] valid;
    logic [NUM_STAGES-1:0] load;
  } aessb_ctl_t;

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int k);
    logic [15:0] d;
    d = {b, b} << k;
    return d[15:8];
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] aa;
    acc = '0;
    aa  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ aa;
      end
      aa = {aa[6:0], 1'b0} ^ (aa[7] ? GF_POLY : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] gf_sq(input logic [7:0] a);
    return gf_mul(a, a);
  endfunction

  function automatic logic [7:0] affine_fwd(input logic [7:0] b);
    return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ AFFINE_FWD_C;
  endfunction

  function automatic logic [7:0] affine_inv(input logic [7:0] b);
    return rotl8(b, 1) ^ rotl8(b, 3) ^ rotl8(b, 6) ^ AFFINE_INV_C;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/aes_sbox_forward_inverse.sv */
// AES byte substitution, forward S-box and inverse S-box.
//
// Input channel: in_valid / in_stall carry one word per accepted cycle,
// made of in_operation (0 forward, 1 inverse) and the byte in_value_in.
// Output channel: out_valid / out_stall carry out_value_out, one result
// word for every input word, in order.
// A word is taken at a rising edge with valid high and stall low.
//
// Throughput is one word per cycle while out_stall is low. The depth is set
// by the four GF(2^8) multiplies of the x^254 inversion chain, one per
// register stage after the first; the inverse affine map fills the first
// stage and the forward affine map shares the last.
//
// Reset (synchronous, rst_n low) empties every stage; nothing else is held.
// While out_stall is high the pipeline holds its words; empty stages still
// fill, and in_stall rises only when every stage is occupied.
`default_nettype none

module aes_sbox_forward_inverse
  import aessb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_value_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_value_out
);

  aessb_ctl_t ctl;

  // Valid bits and load enables for each stage
  aessb_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Affine maps and the exponentiation chain
  aessb_datapath u_dp (
    .clk           (clk),
    .ctl           (ctl),
    .in_operation  (in_operation),
    .in_value_in   (in_value_in),
    .out_value_out (out_value_out)
  );

  // Hold the input off only when the first stage cannot load
  assign in_stall  = !ctl.load[0];
  assign out_valid = ctl.valid[NUM_STAGES-1];

endmodule

`default_nettype wire

/* hw/rtl/aessb_pipe_ctl.sv */
`default_nettype none

module aessb_pipe_ctl
  import aessb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic out_stall,
  output aessb_ctl_t ctl
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] load;

  // A stage loads when empty or when its word moves on this cycle
  always_comb begin
    load[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      load[i] = !valid_r[i] || load[i+1];
    end
  end

  always_comb begin
    valid_nxt[0] = load[0] ? in_valid : valid_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      valid_nxt[i] = load[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl.valid = valid_r;
  assign ctl.load  = load;

endmodule

`default_nettype wire

/* hw/rtl/aessb_datapath.sv */
`default_nettype none

module aessb_datapath
  import aessb_pkg::*;
(
  input  wire logic       clk,
  input  wire aessb_ctl_t ctl,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_value_in,
  output logic      [7:0] out_value_out
);

  // Field inverse as x^254 = x^252 * x^2, built from x^3, x^15, x^252
  aessb_op_t  op0_r, op1_r, op2_r, op3_r;
  logic [7:0] x0_r;
  logic [7:0] x2_1_r, x3_1_r;
  logic [7:0] x2_2_r, x12_2_r, x15_2_r;
  logic [7:0] x2_3_r, x252_3_r;
  logic [7:0] res4_r;

  logic [7:0] x2_1_nxt, x3_1_nxt;
  logic [7:0] x12_2_nxt, x15_2_nxt;
  logic [7:0] x240_3, x252_3_nxt;
  logic [7:0] inv_4, res4_nxt;
  logic [7:0] x0_nxt;

  always_comb begin
    x0_nxt     = (aessb_op_t'(in_operation) == OP_INV) ? affine_inv(in_value_in) : in_value_in;
    x2_1_nxt   = gf_sq(x0_r);
    x3_1_nxt   = gf_mul(x2_1_nxt, x0_r);
    x12_2_nxt  = gf_sq(gf_sq(x3_1_r));
    x15_2_nxt  = gf_mul(x12_2_nxt, x3_1_r);
    x240_3     = gf_sq(gf_sq(gf_sq(gf_sq(x15_2_r))));
    x252_3_nxt = gf_mul(x240_3, x12_2_r);
    inv_4      = gf_mul(x252_3_r, x2_3_r);
    res4_nxt   = (op3_r == OP_FWD) ? affine_fwd(inv_4) : inv_4;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      op0_r <= aessb_op_t'(in_operation);
      x0_r  <= x0_nxt;
    end
    if (ctl.load[1]) begin
      op1_r  <= op0_r;
      x2_1_r <= x2_1_nxt;
      x3_1_r <= x3_1_nxt;
    end
    if (ctl.load[2]) begin
      op2_r   <= op1_r;
      x2_2_r  <= x2_1_r;
      x12_2_r <= x12_2_nxt;
      x15_2_r <= x15_2_nxt;
    end
    if (ctl.load[3]) begin
      op3_r    <= op2_r;
      x2_3_r   <= x2_2_r;
      x252_3_r <= x252_3_nxt;
    end
    if (ctl.load[4]) begin
      res4_r <= res4_nxt;
    end
  end

  assign out_value_out = res4_r;

endmodule

`default_nettype wire

/* hw/rtl/aessb_checker.sv */
`default_nettype none
`include "aes_sbox_forward_inverse_macros.svh"

module aessb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_value_out
);

  `AESSB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value_out), "stalled result word changed")
  `AESSB_ASSERT_SAME(a_no_stall_free, !out_stall, !in_stall, "input stalled while output drains")
  `AESSB_ASSERT_SAME(a_fell_drained, $fell(out_valid), $past(!out_stall), "result word dropped")
  `AESSB_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid, "result word late")

endmodule

bind aes_sbox_forward_inverse aessb_checker u_aessb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value_out (out_value_out)
);

`default_nettype wire

/* tb/sv/aes_sbox_forward_inverse_test.sv */
`default_nettype none

module aes_sbox_forward_inverse_test;
  import aessb_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 4;
  // Far above what the slowest correct run needs.
  localparam int CYCLE_LIMIT   = 250000;
  localparam int SETTLE_CYCLES = NUM_STAGES + 3;

  // How the result side throttles the block
  typedef enum int {
    STALL_NEVER,
    STALL_RANDOM,
    STALL_RUNS
  } stall_style_t;

  // One accepted word together with the byte it must turn into
  typedef struct {
    aessb_op_t  operation;
    logic [7:0] value_in;
    logic [7:0] value_out;
  } substitution_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic       in_operation = 1'b0;
  logic [7:0] in_value_in  = 8'h00;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_value_out;

  // Substitutions accepted by the block and not yet seen on the result side
  substitution_t awaited_substitutions[$];

  int           error_count      = 0;
  int           cycle_count      = 0;
  bit           sender_bursty    = 1'b0;
  int           burst_left       = 0;
  stall_style_t stall_style      = STALL_NEVER;
  int           long_hold_cycles = 0;

  aes_sbox_forward_inverse u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_value_in  (in_value_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value_out(out_value_out)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Byte substitution predictor
  // ---------------------------------------------------------------------------

  // Shift-and-add multiply in GF(2^8); fold the carry back with the field polynomial
  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] product;
    logic [7:0] addend;
    product = 8'h00;
    addend  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        product = product ^ addend;
      end
      addend = {addend[6:0], 1'b0} ^ (addend[7] ? GF_POLY : 8'h00);
    end
    return product;
  endfunction

  // a^254 = a^2 * a^4 * ... * a^128; yields zero for zero, as the S-box wants
  function automatic logic [7:0] gf_reciprocal(input logic [7:0] a);
    logic [7:0] power;
    logic [7:0] acc;
    power = a;
    acc   = 8'h01;
    for (int k = 1; k < 8; k++) begin
      power = gf_times(power, power);
      acc   = gf_times(acc, power);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] b, input int k);
    logic [7:0] left_part;
    logic [7:0] right_part;
    left_part  = b << k;
    right_part = b >> (8 - k);
    return left_part | right_part;
  endfunction

  function automatic logic [7:0] forward_affine(input logic [7:0] b);
    return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ AFFINE_FWD_C;
  endfunction

  function automatic logic [7:0] inverse_affine(input logic [7:0] b);
    return rol8(b, 1) ^ rol8(b, 3) ^ rol8(b, 6) ^ AFFINE_INV_C;
  endfunction

  // Forward: invert then affine. Inverse: undo the affine then invert.
  function automatic logic [7:0] substitute_byte(input aessb_op_t op, input logic [7:0] b);
    if (op == OP_INV) begin
      return gf_reciprocal(inverse_affine(b));
    end
    return forward_affine(gf_reciprocal(b));
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until the block takes it. Valid is left high so
  // that the next word follows on the very next cycle; a gap, when due, is
  // taken before the word is offered.
  task automatic send_word(input aessb_op_t op, input logic [7:0] value);
    substitution_t sub;
    if (sender_bursty && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(1, 18);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value_in  <= value;
    sub.operation = op;
    sub.value_in  = value;
    sub.value_out = substitute_byte(op, value);
    do @(posedge clk); while (in_stall);
    awaited_substitutions.push_back(sub);
    if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic send_random_words(input int count);
    repeat (count) begin
      send_word(aessb_op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Drop valid, wait for every outstanding word, then let the pipe settle
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (awaited_substitutions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input bit bursty, input stall_style_t style);
    sender_bursty = bursty;
    burst_left    = 0;
    stall_style   = style;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall generator
  // ---------------------------------------------------------------------------

  // A requested long hold takes priority and is counted out here; otherwise
  // stall per cycle at random, or in runs of random length, or not at all.
  initial begin : stall_generator
    int  run_left;
    bit  run_stalled;
    run_left    = 0;
    run_stalled = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (long_hold_cycles) @(posedge clk);
        long_hold_cycles = 0;
        out_stall <= 1'b0;
      end else begin
        case (stall_style)
          STALL_RANDOM: begin
            out_stall <= ($urandom_range(0, 99) < 35);
          end
          STALL_RUNS: begin
            if (run_left == 0) begin
              run_stalled = ~run_stalled;
              run_left    = $urandom_range(1, 12);
            end
            run_left--;
            out_stall <= run_stalled;
          end
          default: begin
            out_stall <= 1'b0;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  // Compare each result word taken from the block with the oldest awaited one
  always @(posedge clk) begin : result_check
    substitution_t oldest;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_substitutions.size() == 0) begin
        $error("value_out: expected no word, actual %02h", out_value_out);
        error_count++;
      end else begin
        oldest = awaited_substitutions.pop_front();
        if (out_value_out !== oldest.value_out) begin
          $error("value_out: expected %02h, actual %02h (%s of %02h)",
                 oldest.value_out, out_value_out, oldest.operation.name(),
                 oldest.value_in);
          error_count++;
        end
      end
    end
  end

  // Watchdog: give up on a hung pipeline
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[aes_sbox_forward_inverse] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes and single-bit bytes in both directions. Zero maps to 0x63
  // forward, and 0x63 back to zero inverse, which exercises the zero inverse.
  task automatic test_corner_bytes();
    logic [7:0] corners[10];
    corners = '{8'h00, 8'h01, 8'h02, 8'h55, 8'h63, 8'h7F, 8'h80, 8'hAA, 8'hFE, 8'hFF};
    set_idling(1'b0, STALL_NEVER);
    foreach (corners[i]) begin
      send_word(OP_FWD, corners[i]);
      send_word(OP_INV, corners[i]);
    end
    finish_phase();
  endtask

  // Full rate on both sides: a word in and a word out every cycle
  task automatic test_back_to_back();
    set_idling(1'b0, STALL_NEVER);
    send_random_words(300);
    finish_phase();
  endtask

  // Sender in bursts, receiver always ready
  task automatic test_sender_bursts();
    set_idling(1'b1, STALL_NEVER);
    send_random_words(400);
    finish_phase();
  endtask

  // Sender flat out, receiver stalling at random
  task automatic test_receiver_stalls();
    set_idling(1'b0, STALL_RANDOM);
    send_random_words(400);
    finish_phase();
  endtask

  // Both sides idle, so gaps land on every stage of the pipe
  task automatic test_both_sides_idle();
    set_idling(1'b1, STALL_RUNS);
    send_random_words(325);
    set_idling(1'b1, STALL_RANDOM);
    send_random_words(325);
    finish_phase();
  endtask

  // Hold the result side off long enough for every stage to fill and in_stall
  // to rise, while the sender keeps offering words
  task automatic test_long_hold();
    set_idling(1'b0, STALL_NEVER);
    long_hold_cycles = 60;
    send_random_words(100);
    set_idling(1'b1, STALL_RUNS);
    long_hold_cycles = 40;
    send_random_words(100);
    finish_phase();
  endtask

  initial begin : test_sequence
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_bytes();
    test_back_to_back();
    test_sender_bursts();
    test_receiver_stalls();
    test_both_sides_idle();
    test_long_hold();
    if (error_count == 0) begin
      $display("[aes_sbox_forward_inverse] OK");
    end else begin
      $display("[aes_sbox_forward_inverse] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
